// File: hdl/abrc_pkg.sv
// Shared types, codes and reset constants for the alarm buzzer ramp controller.
package abrc_pkg;

	// Configuration register widths and index width
	localparam int unsigned SEC_W      = 17;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned CFG_IDX_W  = 3;

	// Time field widths
	localparam int unsigned TIME_W = 32;
	localparam int unsigned ID_W   = 8;

	// Configuration reset values
	localparam logic [SEC_W-1:0] AUTO_OFF_RST  = SEC_W'(1800);
	localparam logic [SEC_W-1:0] SLOW_STG_RST  = SEC_W'(30);
	localparam logic [SEC_W-1:0] FAST_END_RST  = SEC_W'(60);
	localparam logic [MS_W-1:0]  SLOW_ON_RST   = MS_W'(500);
	localparam logic [MS_W-1:0]  SLOW_OFF_RST  = MS_W'(1500);
	localparam logic [MS_W-1:0]  FAST_ON_RST   = MS_W'(200);
	localparam logic [MS_W-1:0]  FAST_OFF_RST  = MS_W'(200);

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AUTO_OFF = 3'd0,
		CFG_SLOW_STG = 3'd1,
		CFG_FAST_END = 3'd2,
		CFG_SLOW_ON  = 3'd3,
		CFG_SLOW_OFF = 3'd4,
		CFG_FAST_ON  = 3'd5,
		CFG_FAST_OFF = 3'd6
	} cfg_idx_t;

	// Request action codes
	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_TRIGGER = 2'd1,
		ACT_STOP    = 2'd2,
		ACT_RESUME  = 2'd3
	} action_t;

	// Ramp stage, held one-hot internally
	typedef enum logic [2:0] {
		STG_SLOW = 3'b001,
		STG_FAST = 3'b010,
		STG_CONT = 3'b100
	} stage_t;

	// Ramp stage codes as shown on the result
	localparam logic [1:0] RAMP_SLOW = 2'd0;
	localparam logic [1:0] RAMP_FAST = 2'd1;
	localparam logic [1:0] RAMP_CONT = 2'd2;

	// Configuration bundle
	typedef struct packed {
		logic [SEC_W-1:0] auto_off_seconds;
		logic [SEC_W-1:0] slow_stage_seconds;
		logic [SEC_W-1:0] fast_stage_end_seconds;
		logic [MS_W-1:0]  slow_on_ms;
		logic [MS_W-1:0]  slow_off_ms;
		logic [MS_W-1:0]  fast_on_ms;
		logic [MS_W-1:0]  fast_off_ms;
	} cfg_t;

	// Input request payload
	typedef struct packed {
		logic [1:0]        action;
		logic [ID_W-1:0]   alarm_id;
		logic [TIME_W-1:0] resume_start_seconds;
		logic [TIME_W-1:0] now_seconds;
		logic [TIME_W-1:0] now_ms;
	} in_req_t;

	// Result payload
	typedef struct packed {
		logic            ringing;
		logic [ID_W-1:0] active_alarm;
		logic [1:0]      ramp_stage;
		logic            buzzer_on;
		logic            auto_stopped;
	} out_res_t;

	// One-hot stage to result code
	function automatic logic [1:0] stage_code(input stage_t stg);
		logic [1:0] code;
		code = RAMP_SLOW;
		unique case (stg)
			STG_SLOW: code = RAMP_SLOW;
			STG_FAST: code = RAMP_FAST;
			STG_CONT: code = RAMP_CONT;
			default:  code = RAMP_SLOW;
		endcase
		return code;
	endfunction

endpackage

// File: hdl/abrc_cfg_regs.sv
// Configuration register file for the alarm buzzer ramp controller.
module abrc_cfg_regs import abrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_off_seconds       <= AUTO_OFF_RST;
			cfg_q.slow_stage_seconds     <= SLOW_STG_RST;
			cfg_q.fast_stage_end_seconds <= FAST_END_RST;
			cfg_q.slow_on_ms             <= SLOW_ON_RST;
			cfg_q.slow_off_ms            <= SLOW_OFF_RST;
			cfg_q.fast_on_ms             <= FAST_ON_RST;
			cfg_q.fast_off_ms            <= FAST_OFF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AUTO_OFF: cfg_q.auto_off_seconds       <= cfg_wdata[SEC_W-1:0];
				CFG_SLOW_STG: cfg_q.slow_stage_seconds     <= cfg_wdata[SEC_W-1:0];
				CFG_FAST_END: cfg_q.fast_stage_end_seconds <= cfg_wdata[SEC_W-1:0];
				CFG_SLOW_ON:  cfg_q.slow_on_ms             <= cfg_wdata[MS_W-1:0];
				CFG_SLOW_OFF: cfg_q.slow_off_ms            <= cfg_wdata[MS_W-1:0];
				CFG_FAST_ON:  cfg_q.fast_on_ms             <= cfg_wdata[MS_W-1:0];
				CFG_FAST_OFF: cfg_q.fast_off_ms            <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/abrc_core.sv
// Ringing state and per-request next-state and result logic.
module abrc_core import abrc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_en,
	input  in_req_t  req,
	input  cfg_t     cfg,
	output out_res_t res
);

	logic              ringing_q;
	logic [ID_W-1:0]   alarm_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] toggle_ms_q;
	stage_t            stage_q;
	logic              phase_q;

	logic              ringing_d;
	logic [ID_W-1:0]   alarm_d;
	logic [TIME_W-1:0] start_d;
	logic [TIME_W-1:0] toggle_ms_d;
	stage_t            stage_d;
	logic              phase_d;
	logic              auto_stop;

	logic [TIME_W-1:0] tick_elapsed;
	logic [TIME_W-1:0] resume_elapsed;
	logic [TIME_W-1:0] since_ms;
	logic [MS_W-1:0]   on_ms;
	logic [MS_W-1:0]   off_ms;
	stage_t            tick_stage;
	stage_t            resume_stage;

	// Elapsed times, all mod 2^32
	assign tick_elapsed   = req.now_seconds - start_q;
	assign resume_elapsed = req.now_seconds - req.resume_start_seconds;
	assign since_ms       = req.now_ms - toggle_ms_q;

	// At most one stage step per tick
	always_comb begin
		tick_stage = stage_q;
		if (stage_q == STG_SLOW && tick_elapsed >= TIME_W'(cfg.slow_stage_seconds)) begin
			tick_stage = STG_FAST;
		end else if (stage_q == STG_FAST &&
				tick_elapsed >= TIME_W'(cfg.fast_stage_end_seconds)) begin
			tick_stage = STG_CONT;
		end
	end

	// Resume picks the stage straight from elapsed time
	always_comb begin
		if (resume_elapsed >= TIME_W'(cfg.fast_stage_end_seconds)) begin
			resume_stage = STG_CONT;
		end else if (resume_elapsed >= TIME_W'(cfg.slow_stage_seconds)) begin
			resume_stage = STG_FAST;
		end else begin
			resume_stage = STG_SLOW;
		end
	end

	// Beep times follow the stage after the step
	assign on_ms  = (tick_stage == STG_SLOW) ? cfg.slow_on_ms : cfg.fast_on_ms;
	assign off_ms = (tick_stage == STG_SLOW) ? cfg.slow_off_ms : cfg.fast_off_ms;

	// Next state for one request
	always_comb begin
		ringing_d   = ringing_q;
		alarm_d     = alarm_q;
		start_d     = start_q;
		toggle_ms_d = toggle_ms_q;
		stage_d     = stage_q;
		phase_d     = phase_q;
		auto_stop   = 1'b0;
		unique case (action_t'(req.action))
			ACT_TICK: begin
				if (ringing_q) begin
					if (tick_elapsed >= TIME_W'(cfg.auto_off_seconds)) begin
						ringing_d = 1'b0;
						alarm_d   = '0;
						stage_d   = STG_SLOW;
						phase_d   = 1'b0;
						auto_stop = 1'b1;
					end else begin
						stage_d = tick_stage;
						if (tick_stage != STG_CONT) begin
							if (phase_q && since_ms >= TIME_W'(on_ms)) begin
								phase_d     = 1'b0;
								toggle_ms_d = req.now_ms;
							end else if (!phase_q && since_ms >= TIME_W'(off_ms)) begin
								phase_d     = 1'b1;
								toggle_ms_d = req.now_ms;
							end
						end
					end
				end
			end
			ACT_TRIGGER, ACT_RESUME: begin
				if (!ringing_q) begin
					ringing_d   = 1'b1;
					alarm_d     = req.alarm_id;
					toggle_ms_d = req.now_ms;
					phase_d     = 1'b1;
					if (action_t'(req.action) == ACT_RESUME) begin
						start_d = req.resume_start_seconds;
						stage_d = resume_stage;
					end else begin
						start_d = req.now_seconds;
						stage_d = STG_SLOW;
					end
				end
			end
			ACT_STOP: begin
				if (ringing_q) begin
					ringing_d = 1'b0;
					alarm_d   = '0;
					stage_d   = STG_SLOW;
					phase_d   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// State update when a request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ringing_q   <= 1'b0;
			alarm_q     <= '0;
			start_q     <= '0;
			toggle_ms_q <= '0;
			stage_q     <= STG_SLOW;
			phase_q     <= 1'b0;
		end else if (req_en) begin
			ringing_q   <= ringing_d;
			alarm_q     <= alarm_d;
			start_q     <= start_d;
			toggle_ms_q <= toggle_ms_d;
			stage_q     <= stage_d;
			phase_q     <= phase_d;
		end
	end

	// Result seen after the action
	always_comb begin
		res.ringing      = ringing_d;
		res.active_alarm = ringing_d ? alarm_d : '0;
		res.ramp_stage   = ringing_d ? stage_code(stage_d) : RAMP_SLOW;
		res.buzzer_on    = ringing_d && (stage_d == STG_CONT || phase_d);
		res.auto_stopped = auto_stop;
	end

endmodule

// File: hdl/alarm_buzzer_ramp_controller_top.sv
// Top level of the alarm buzzer ramp controller: request and result registers.
// Each request (tick, trigger, stop or resume) yields exactly one result. It passes
// through the request register, where the ringing state and beep timer are updated,
// and then the result register. A new request can be taken every cycle; the rate is
// one request per cycle, set by the single state update done in the request register
// stage, and it drops only while a result is stalled with the request register also
// full. Configuration registers reset to their default ramp timings; the user must
// write them only while the block is idle, and the block itself does not enforce it.
module alarm_buzzer_ramp_controller_top import abrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_req_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_res_t              out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t     cfg;
	in_req_t  req_s1;
	logic     valid_s1;
	out_res_t res;
	out_res_t out_data_q;
	logic     out_valid_q;
	logic     out_free;
	logic     adv_s1;
	logic     in_fire;

	abrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: request stage moves on when the result register frees up
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1 <= in_data;
		end
	end

	abrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req_en (adv_s1),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: hdl/abrc_checker.sv
// Port-level checks for the alarm buzzer ramp controller, bound to the top level.
module abrc_checker import abrc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_stall,
	input out_res_t out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Idle result shows no alarm, stage or buzzer
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ringing |->
			out_data.active_alarm == '0 && out_data.ramp_stage == RAMP_SLOW &&
			!out_data.buzzer_on)
		else $error("idle result carries ringing fields");

	// Auto-off always ends ringing
	a_auto_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.auto_stopped |-> !out_data.ringing)
		else $error("auto-off result still ringing");

	// Continuous tone always drives the buzzer
	a_cont_buzz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ringing && out_data.ramp_stage == RAMP_CONT |->
			out_data.buzzer_on)
		else $error("continuous stage without buzzer");

endmodule

bind alarm_buzzer_ramp_controller_top abrc_checker u_abrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the alarm buzzer ramp controller top level.
module testbench;
	import abrc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT   = 2000;
	localparam int unsigned IDLE_PCT         = 38;
	localparam int unsigned RANDOM_PHASES    = 10;
	localparam int unsigned ITEMS_PER_PHASE  = 175;
	localparam int unsigned BURST_PHASE      = 5;
	localparam int unsigned LONG_HOLD_AT     = 600;
	localparam int unsigned LONG_HOLD_CYCLES = 60;
	localparam int unsigned DRAIN_CYCLES     = 4;
	localparam int unsigned RESET_CYCLES     = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
	localparam logic [SEC_W-1:0]     SEC_RANGE_TOP  = SEC_W'(86400);

	// Register settings used per phase
	typedef enum int {
		SET_KEEP,
		SET_ZERO,
		SET_ALL_ONES,
		SET_RANGE_TOP,
		SET_RANDOM
	} setting_kind_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_req_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_res_t              out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_AUTO_OFF;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Ringing state and register copy used for prediction
	logic [SEC_W-1:0]  cf_auto_off = AUTO_OFF_RST;
	logic [SEC_W-1:0]  cf_slow_stg = SLOW_STG_RST;
	logic [SEC_W-1:0]  cf_fast_end = FAST_END_RST;
	logic [MS_W-1:0]   cf_slow_on  = SLOW_ON_RST;
	logic [MS_W-1:0]   cf_slow_off = SLOW_OFF_RST;
	logic [MS_W-1:0]   cf_fast_on  = FAST_ON_RST;
	logic [MS_W-1:0]   cf_fast_off = FAST_OFF_RST;
	logic              rg_on        = 1'b0;
	logic [ID_W-1:0]   rg_alarm     = '0;
	logic [TIME_W-1:0] rg_start     = '0;
	logic [TIME_W-1:0] rg_toggle_ms = '0;
	logic [1:0]        rg_stage     = RAMP_SLOW;
	logic              rg_beep      = 1'b0;

	// Request and result bookkeeping
	in_req_t  request_q[$];
	out_res_t ring_result_q[$];
	logic [CFG_DATA_W-1:0] next_cfg [2**CFG_IDX_W];
	logic [TIME_W-1:0] clock_s;
	logic [TIME_W-1:0] clock_ms;
	int unsigned phase_items    = 0;
	int unsigned n_accepted     = 0;
	int unsigned n_results      = 0;
	int unsigned n_auto_stops   = 0;
	int unsigned n_cont_results = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned hold_left      = 0;
	bit          long_hold_done = 1'b0;
	bit          no_idle        = 1'b0;

	alarm_buzzer_ramp_controller_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void halt_ring();
		rg_on    = 1'b0;
		rg_alarm = '0;
		rg_stage = RAMP_SLOW;
		rg_beep  = 1'b0;
	endfunction

	function automatic void start_ring(input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] start_s, input logic [TIME_W-1:0] now_ms);
		rg_on        = 1'b1;
		rg_alarm     = id;
		rg_start     = start_s;
		rg_toggle_ms = now_ms;
		rg_beep      = 1'b1;
		rg_stage     = RAMP_SLOW;
	endfunction

	// Apply one request to the ringing state and return the result it causes
	function automatic out_res_t predict_ring_result(input in_req_t req);
		out_res_t          res;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] since;
		logic [MS_W-1:0]   phase_ms;
		logic              stopped;
		stopped = 1'b0;
		case (action_t'(req.action))
			ACT_TICK: begin
				if (rg_on) begin
					elapsed = req.now_seconds - rg_start;
					if (elapsed >= cf_auto_off) begin
						halt_ring();
						stopped = 1'b1;
					end else begin
						// at most one stage step per tick
						if (rg_stage == RAMP_SLOW && elapsed >= cf_slow_stg)
							rg_stage = RAMP_FAST;
						else if (rg_stage == RAMP_FAST && elapsed >= cf_fast_end)
							rg_stage = RAMP_CONT;
						if (rg_stage != RAMP_CONT) begin
							if (rg_stage == RAMP_SLOW)
								phase_ms = rg_beep ? cf_slow_on : cf_slow_off;
							else
								phase_ms = rg_beep ? cf_fast_on : cf_fast_off;
							since = req.now_ms - rg_toggle_ms;
							if (since >= phase_ms) begin
								rg_beep      = !rg_beep;
								rg_toggle_ms = req.now_ms;
							end
						end
					end
				end
			end
			ACT_TRIGGER: begin
				if (!rg_on)
					start_ring(req.alarm_id, req.now_seconds, req.now_ms);
			end
			ACT_STOP: begin
				if (rg_on)
					halt_ring();
			end
			ACT_RESUME: begin
				if (!rg_on) begin
					start_ring(req.alarm_id, req.resume_start_seconds, req.now_ms);
					elapsed = req.now_seconds - req.resume_start_seconds;
					if (elapsed >= cf_fast_end)
						rg_stage = RAMP_CONT;
					else if (elapsed >= cf_slow_stg)
						rg_stage = RAMP_FAST;
				end
			end
			default: ;
		endcase
		res.ringing      = rg_on;
		res.active_alarm = rg_on ? rg_alarm : '0;
		res.ramp_stage   = rg_on ? rg_stage : RAMP_SLOW;
		res.buzzer_on    = rg_on && (rg_stage == RAMP_CONT || rg_beep);
		res.auto_stopped = stopped;
		return res;
	endfunction

	function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_AUTO_OFF: cf_auto_off = val[SEC_W-1:0];
			CFG_SLOW_STG: cf_slow_stg = val[SEC_W-1:0];
			CFG_FAST_END: cf_fast_end = val[SEC_W-1:0];
			CFG_SLOW_ON:  cf_slow_on  = val[MS_W-1:0];
			CFG_SLOW_OFF: cf_slow_off = val[MS_W-1:0];
			CFG_FAST_ON:  cf_fast_on  = val[MS_W-1:0];
			CFG_FAST_OFF: cf_fast_off = val[MS_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic queue_req(input action_t act, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] start_s, input logic [TIME_W-1:0] now_s,
			input logic [TIME_W-1:0] now_ms, input bit counted);
		in_req_t req;
		req.action               = act;
		req.alarm_id             = id;
		req.resume_start_seconds = start_s;
		req.now_seconds          = now_s;
		req.now_ms               = now_ms;
		request_q.push_back(req);
		if (counted)
			phase_items++;
	endtask

	// Pick register values for a phase; the unused index always gets noise
	task automatic pick_settings(input setting_kind_t kind);
		int i;
		for (i = 0; i < 2**CFG_IDX_W; i++) begin
			case (kind)
				SET_ZERO:      next_cfg[i] = '0;
				SET_ALL_ONES:  next_cfg[i] = '1;
				SET_RANGE_TOP: next_cfg[i] = (i <= CFG_FAST_END) ? SEC_RANGE_TOP
						: CFG_DATA_W'(17'h0FFFF);
				default: begin
					if (i == CFG_AUTO_OFF)
						next_cfg[i] = CFG_DATA_W'($urandom_range(4, 160));
					else if (i == CFG_SLOW_STG)
						next_cfg[i] = CFG_DATA_W'($urandom_range(0, 30));
					else if (i == CFG_FAST_END)
						next_cfg[i] = CFG_DATA_W'($urandom_range(0, 60));
					else
						next_cfg[i] = {1'($urandom_range(1)),
								16'($urandom_range(0, 1200))};
				end
			endcase
		end
		next_cfg[CFG_UNUSED_IDX] = CFG_DATA_W'($urandom);
	endtask

	// Back-to-back register writes; the block is idle here
	task automatic write_settings();
		int i;
		for (i = 0; i < 2**CFG_IDX_W; i++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= next_cfg[i];
			store_setting(CFG_IDX_W'(i), next_cfg[i]);
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One ringing episode: start, a run of ticks with some noise, maybe a stop
	task automatic queue_episode();
		int unsigned       n_ticks;
		int unsigned       sec_step;
		int unsigned       ms_span;
		int unsigned       k;
		int unsigned       r;
		logic [TIME_W-1:0] origin;
		sec_step = 32'(cf_fast_end) / 8 + 1;
		ms_span  = (32'(cf_slow_on) + 32'(cf_slow_off) + 32'(cf_fast_on)
				+ 32'(cf_fast_off)) / 2 + 1;
		r = $urandom_range(99);
		if (r < 65) begin
			queue_req(ACT_TRIGGER, ID_W'($urandom), $urandom, clock_s, clock_ms, 1'b1);
		end else begin
			if (r < 95)
				origin = clock_s - $urandom_range(0, 32'(cf_fast_end) * 5 / 4 + 2);
			else
				origin = $urandom;
			queue_req(ACT_RESUME, ID_W'($urandom), origin, clock_s, clock_ms, 1'b1);
		end
		n_ticks = $urandom_range(2, 24);
		for (k = 0; k < n_ticks; k++) begin
			if ($urandom_range(99) < 8)
				clock_s += $urandom_range(0, 32'(cf_auto_off) + 2);
			else
				clock_s += $urandom_range(0, sec_step);
			clock_ms += $urandom_range(0, ms_span);
			r = $urandom_range(99);
			if (r < 4)
				queue_req(ACT_TRIGGER, ID_W'($urandom), $urandom, clock_s, clock_ms, 1'b1);
			else if (r < 7)
				queue_req(ACT_RESUME, ID_W'($urandom), $urandom, clock_s, clock_ms, 1'b1);
			else if (r < 9)
				queue_req(action_t'($urandom_range(3)), ID_W'($urandom), $urandom,
						$urandom, $urandom, 1'b1);
			else
				queue_req(ACT_TICK, ID_W'($urandom), $urandom, clock_s, clock_ms, 1'b1);
		end
		if ($urandom_range(99) < 55)
			queue_req(ACT_STOP, ID_W'($urandom), $urandom, clock_s, clock_ms, 1'b1);
	endtask

	task automatic wait_drained();
		while (request_q.size() != 0 || ring_result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Request driver: predicts on acceptance, holds a stalled request
	always @(posedge clk) begin : request_driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				ring_result_q.push_back(predict_ring_result(in_data));
				void'(request_q.pop_front());
				n_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (request_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					in_data  <= request_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [ID_W-1:0] want,
			input logic [ID_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result monitor: checks against the oldest expectation, drives stall
	always @(posedge clk) begin : result_monitor
		out_res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (ring_result_q.size() == 0) begin
					$display("%0t: result with nothing expected, expected none actual %h",
							$time, out_data);
					mismatch_count++;
				end else begin
					want = ring_result_q.pop_front();
					if (want.auto_stopped)
						n_auto_stops++;
					if (want.ringing && want.ramp_stage == RAMP_CONT)
						n_cont_results++;
					check_field("ringing", ID_W'(want.ringing), ID_W'(out_data.ringing));
					check_field("active_alarm", want.active_alarm, out_data.active_alarm);
					check_field("ramp_stage", ID_W'(want.ramp_stage),
							ID_W'(out_data.ramp_stage));
					check_field("buzzer_on", ID_W'(want.buzzer_on), ID_W'(out_data.buzzer_on));
					check_field("auto_stopped", ID_W'(want.auto_stopped),
							ID_W'(out_data.auto_stopped));
				end
			end
			// one long hold-off so the block fills and stalls its input
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_hold_done && n_results >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog on cycles with no request or result accepted
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: nothing accepted for %0d cycles", $time, quiet_cycles);
			$display("FAIL alarm_buzzer_ramp_controller_top");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned       p;
		setting_kind_t     kind;
		logic [TIME_W-1:0] s0;
		logic [TIME_W-1:0] m0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, wraps, stage steps, auto-off, ignored actions
		s0 = 32'hFFFF_FFF0;
		m0 = 32'hFFFF_FF00;
		queue_req(ACT_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_req(ACT_STOP, 8'h00, '0, '0, '0, 1'b1);
		queue_req(ACT_TRIGGER, 8'hFF, '0, s0, m0, 1'b1);
		queue_req(ACT_TRIGGER, 8'h12, '0, s0, m0, 1'b1);
		queue_req(ACT_RESUME, 8'h34, s0 - 100, s0, m0, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 1, m0 + 499, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 2, m0 + 500, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 3, m0 + 1999, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 4, m0 + 2000, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 30, m0 + 2100, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 45, m0 + 2300, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 60, m0 + 2350, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 1799, m0 + 9000, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 1800, m0 + 9001, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, s0 + 1801, m0 + 9002, 1'b1);
		queue_req(ACT_STOP, 8'h00, '0, s0 + 1801, m0 + 9002, 1'b1);
		queue_req(ACT_RESUME, 8'h00, 32'd100, 32'd160, '0, 1'b1);
		queue_req(ACT_STOP, 8'h00, '0, 32'd160, '0, 1'b1);
		queue_req(ACT_RESUME, 8'hA5, '0, 32'd30, 32'h8000_0000, 1'b1);
		queue_req(ACT_TICK, 8'h00, '0, 32'd59, 32'h8000_00C7, 1'b1);
		queue_req(ACT_STOP, 8'h00, '0, 32'd59, 32'h8000_00C7, 1'b1);
		queue_req(ACT_RESUME, 8'h5A, 32'hFFFF_FFFF, 32'h0000_001C, 32'd7, 1'b1);
		queue_req(ACT_STOP, 8'h00, '0, 32'h0000_001C, 32'd7, 1'b1);
		queue_req(ACT_TRIGGER, 8'h00, 32'hFFFF_FFFF, '0, '0, 1'b1);
		queue_req(ACT_STOP, 8'h00, '0, '0, '0, 1'b1);
		wait_drained();

		// Random phases, each under its own register setting
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       kind = SET_KEEP;
				1:       kind = SET_ZERO;
				2:       kind = SET_ALL_ONES;
				3:       kind = SET_RANGE_TOP;
				default: kind = SET_RANDOM;
			endcase
			if (kind != SET_KEEP) begin
				pick_settings(kind);
				write_settings();
			end
			no_idle = (p == BURST_PHASE);
			if (p % 2 == 1)
				clock_s = 32'hFFFF_FFFF - $urandom_range(0, 4000);
			else
				clock_s = $urandom;
			if (p % 3 == 0)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			else
				clock_ms = $urandom;
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				// stray tick or stop between episodes, mostly while idle
				if ($urandom_range(99) < 30) begin
					clock_s  += $urandom_range(0, 3);
					clock_ms += $urandom_range(0, 500);
					queue_req($urandom_range(1) ? ACT_TICK : ACT_STOP, ID_W'($urandom),
							$urandom, clock_s, clock_ms, 1'b0);
				end
				queue_episode();
			end
			wait_drained();
		end
		no_idle = 1'b0;

		$display("Covered %0d requests under %0d register settings incl. zero and all-ones,",
				n_accepted, RANDOM_PHASES);
		$display("with %0d auto-off stops and %0d continuous-tone results checked.",
				n_auto_stops, n_cont_results);
		if (mismatch_count == 0) begin
			$display("PASS alarm_buzzer_ramp_controller_top");
		end else begin
			$display("FAIL alarm_buzzer_ramp_controller_top");
		end
		$finish;
	end

endmodule
